FILE: src/rti_pkg.sv
`default_nettype none
package rti_pkg;

   localparam int CW            = 32;
   localparam int EW            = CW + 1;
   localparam int HW            = 2 * CW + 2;
   localparam int QW            = 2 * EW + 1;
   localparam int LOW           = 33;
   localparam int PPW           = 68;
   localparam int DOTW          = 104;
   localparam int QBITS         = 63;
   localparam int TOLW          = 16;
   localparam int TLO           = 32;
   localparam int PW            = 96;
   localparam int RSPW          = 104;
   localparam int REQW          = 9 * CW;
   localparam int CSR_AW        = 3;
   localparam int FRAC_BITS_DEF = 16;

   localparam int FRONT_STAGES  = 3;
   localparam int DOT_STAGES    = 5;
   localparam int POINT_STAGES  = 2;

   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   localparam logic [CW-1:0]   DIR_Z_RST = 32'h0001_0000;
   localparam logic [TOLW-1:0] TOL_RST   = 16'd1;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ORG_X,
      CSR_ORG_Y,
      CSR_ORG_Z,
      CSR_DIR_X,
      CSR_DIR_Y,
      CSR_DIR_Z,
      CSR_TOL
   } csr_idx_type;

   typedef struct packed {
      logic [2:0][CW-1:0] org;
      logic [2:0][CW-1:0] dir;
      logic [TOLW-1:0]    tol;
   } ray_type;

   typedef struct packed {
      logic             hit;
      logic             ovf;
      logic [DOTW-1:0]  rem;
      logic [DOTW-1:0]  den;
      logic [QBITS-1:0] nq;
   } div_req_type;

   typedef struct packed {
      logic             hit;
      logic             ovf;
      logic             rem_nz;
      logic [QBITS-1:0] q;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: src/rti_front.sv
`default_nettype none
module rti_front (
   input  logic                                    clock,
   input  logic [rti_pkg::FRONT_STAGES-1:0]        en,
   input  rti_pkg::ray_type                        ray,
   input  logic [8:0][rti_pkg::CW-1:0]             vert,
   output logic signed [rti_pkg::EW-1:0]           e1_o [3],
   output logic signed [rti_pkg::EW-1:0]           e2_o [3],
   output logic signed [rti_pkg::EW-1:0]           s_o  [3],
   output logic signed [rti_pkg::HW-1:0]           h_o  [3],
   output logic signed [rti_pkg::QW-1:0]           q_o  [3]
);

   logic signed [rti_pkg::EW-1:0]   e1_s1_in [3], e1_s1_ff [3];
   logic signed [rti_pkg::EW-1:0]   e2_s1_in [3], e2_s1_ff [3];
   logic signed [rti_pkg::EW-1:0]   s_s1_in  [3], s_s1_ff  [3];
   logic signed [rti_pkg::HW-2:0]   hpa_in [3], hpa_ff [3], hpb_in [3], hpb_ff [3];
   logic signed [rti_pkg::QW-2:0]   qpa_in [3], qpa_ff [3], qpb_in [3], qpb_ff [3];
   logic signed [rti_pkg::EW-1:0]   e1_s2_ff [3], e2_s2_ff [3], s_s2_ff [3];
   logic signed [rti_pkg::HW-1:0]   h_in [3], h_ff [3];
   logic signed [rti_pkg::QW-1:0]   q_in [3], q_ff [3];
   logic signed [rti_pkg::EW-1:0]   e1_s3_ff [3], e2_s3_ff [3], s_s3_ff [3];

   // edges and origin offset
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1_s1_in[k] = $signed({vert[3+k][rti_pkg::CW-1], vert[3+k]})
                     - $signed({vert[k][rti_pkg::CW-1], vert[k]});
         e2_s1_in[k] = $signed({vert[6+k][rti_pkg::CW-1], vert[6+k]})
                     - $signed({vert[k][rti_pkg::CW-1], vert[k]});
         s_s1_in[k]  = $signed({ray.org[k][rti_pkg::CW-1], ray.org[k]})
                     - $signed({vert[k][rti_pkg::CW-1], vert[k]});
      end
   end

   // cross product terms
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hpa_in[k] = $signed(ray.dir[rti_pkg::NXT[k]]) * e2_s1_ff[rti_pkg::PRV[k]];
         hpb_in[k] = $signed(ray.dir[rti_pkg::PRV[k]]) * e2_s1_ff[rti_pkg::NXT[k]];
         qpa_in[k] = s_s1_ff[rti_pkg::NXT[k]] * e1_s1_ff[rti_pkg::PRV[k]];
         qpb_in[k] = s_s1_ff[rti_pkg::PRV[k]] * e1_s1_ff[rti_pkg::NXT[k]];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         h_in[k] = rti_pkg::HW'(hpa_ff[k]) - rti_pkg::HW'(hpb_ff[k]);
         q_in[k] = rti_pkg::QW'(qpa_ff[k]) - rti_pkg::QW'(qpb_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e1_s1_ff <= e1_s1_in;
         e2_s1_ff <= e2_s1_in;
         s_s1_ff  <= s_s1_in;
      end
      if (en[1]) begin
         hpa_ff   <= hpa_in;
         hpb_ff   <= hpb_in;
         qpa_ff   <= qpa_in;
         qpb_ff   <= qpb_in;
         e1_s2_ff <= e1_s1_ff;
         e2_s2_ff <= e2_s1_ff;
         s_s2_ff  <= s_s1_ff;
      end
      if (en[2]) begin
         h_ff     <= h_in;
         q_ff     <= q_in;
         e1_s3_ff <= e1_s2_ff;
         e2_s3_ff <= e2_s2_ff;
         s_s3_ff  <= s_s2_ff;
      end
   end

   assign e1_o = e1_s3_ff;
   assign e2_o = e2_s3_ff;
   assign s_o  = s_s3_ff;
   assign h_o  = h_ff;
   assign q_o  = q_ff;

endmodule
`default_nettype wire

FILE: src/rti_dot.sv
`default_nettype none
module rti_dot #(
   parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic [rti_pkg::DOT_STAGES-1:0]      en,
   input  rti_pkg::ray_type                    ray,
   input  logic signed [rti_pkg::EW-1:0]       e1 [3],
   input  logic signed [rti_pkg::EW-1:0]       e2 [3],
   input  logic signed [rti_pkg::EW-1:0]       s  [3],
   input  logic signed [rti_pkg::HW-1:0]       h  [3],
   input  logic signed [rti_pkg::QW-1:0]       q  [3],
   output rti_pkg::div_req_type                dreq
);

   localparam int NUMW = rti_pkg::DOTW + FRAC_BITS;
   localparam int CMPW = rti_pkg::DOTW + rti_pkg::QBITS;
   localparam int LOW  = rti_pkg::LOW;

   logic signed [rti_pkg::PPW-1:0]  plo_in [4][3], plo_ff [4][3];
   logic signed [rti_pkg::PPW-1:0]  phi_in [4][3], phi_ff [4][3];
   logic signed [rti_pkg::DOTW-1:0] term_in [4][3], term_ff [4][3];
   logic signed [rti_pkg::DOTW-1:0] dot_in [4], dot_ff [4];
   logic signed [rti_pkg::DOTW-1:0] fix_in [4], fix_ff [4];
   rti_pkg::div_req_type            dreq_in, dreq_ff;

   logic signed [rti_pkg::DOTW-1:0] a, un, vn, tn, tol_lim;
   logic signed [rti_pkg::DOTW:0]   uv, a1;
   logic [NUMW-1:0]                 num;

   // split partial products for det, u, v and t numerators
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         plo_in[0][k] = e1[k] * $signed({1'b0, h[k][LOW-1:0]});
         phi_in[0][k] = e1[k] * $signed(h[k][rti_pkg::HW-1:LOW]);
         plo_in[1][k] = s[k] * $signed({1'b0, h[k][LOW-1:0]});
         phi_in[1][k] = s[k] * $signed(h[k][rti_pkg::HW-1:LOW]);
         plo_in[2][k] = $signed(ray.dir[k]) * $signed({1'b0, q[k][LOW-1:0]});
         phi_in[2][k] = $signed(ray.dir[k]) * $signed(q[k][rti_pkg::QW-1:LOW]);
         plo_in[3][k] = e2[k] * $signed({1'b0, q[k][LOW-1:0]});
         phi_in[3][k] = e2[k] * $signed(q[k][rti_pkg::QW-1:LOW]);
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            term_in[j][k] = (rti_pkg::DOTW'(phi_ff[j][k]) <<< LOW)
                          + rti_pkg::DOTW'(plo_ff[j][k]);
         end
         dot_in[j] = term_ff[j][0] + term_ff[j][1] + term_ff[j][2];
         fix_in[j] = dot_ff[0][rti_pkg::DOTW-1] ? -dot_ff[j] : dot_ff[j];
      end
   end

   // tests and divider setup
   always_comb begin
      a       = fix_ff[0];
      un      = fix_ff[1];
      vn      = fix_ff[2];
      tn      = fix_ff[3];
      tol_lim = $signed(rti_pkg::DOTW'(ray.tol) << (2 * FRAC_BITS));
      uv      = (rti_pkg::DOTW+1)'(un) + (rti_pkg::DOTW+1)'(vn);
      a1      = (rti_pkg::DOTW+1)'(a);
      num     = tn[rti_pkg::DOTW-1] ? '0 : {tn, {FRAC_BITS{1'b0}}};

      dreq_in.hit = (a != '0) && (a >= tol_lim) && !un[rti_pkg::DOTW-1] && (un <= a)
                 && !vn[rti_pkg::DOTW-1] && (uv <= a1) && !tn[rti_pkg::DOTW-1];
      dreq_in.ovf = {{(CMPW-NUMW){1'b0}}, num} >= {a, {rti_pkg::QBITS{1'b0}}};
      dreq_in.rem = dreq_in.ovf ? '0 : rti_pkg::DOTW'(num >> rti_pkg::QBITS);
      dreq_in.den = a;
      dreq_in.nq  = num[rti_pkg::QBITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (en[1]) term_ff <= term_in;
      if (en[2]) dot_ff  <= dot_in;
      if (en[3]) fix_ff  <= fix_in;
      if (en[4]) dreq_ff <= dreq_in;
   end

   assign dreq = dreq_ff;

endmodule
`default_nettype wire

FILE: src/rti_div.sv
`default_nettype none
module rti_div (
   input  logic                          clock,
   input  logic [rti_pkg::QBITS-1:0]     en,
   input  rti_pkg::div_req_type          dreq,
   output rti_pkg::div_rsp_type          drsp
);

   rti_pkg::div_req_type st_w [rti_pkg::QBITS+1];

   assign st_w[0] = dreq;

   // one quotient bit per stage, restoring
   for (genvar i = 0; i < rti_pkg::QBITS; i++) begin : g_stage
      rti_pkg::div_req_type        st_in, st_ff;
      logic [rti_pkg::DOTW+1:0]    trial;
      logic                        bor;

      always_comb begin
         trial = {1'b0, st_w[i].rem, st_w[i].nq[rti_pkg::QBITS-1]} - {2'b00, st_w[i].den};
         bor   = trial[rti_pkg::DOTW+1];
         st_in = st_w[i];
         st_in.rem = bor ? {st_w[i].rem[rti_pkg::DOTW-2:0], st_w[i].nq[rti_pkg::QBITS-1]}
                         : trial[rti_pkg::DOTW-1:0];
         st_in.nq  = {st_w[i].nq[rti_pkg::QBITS-2:0], !bor};
      end

      always_ff @(posedge clock) begin
         if (en[i]) st_ff <= st_in;
      end

      assign st_w[i+1] = st_ff;
   end

   assign drsp.hit    = st_w[rti_pkg::QBITS].hit;
   assign drsp.ovf    = st_w[rti_pkg::QBITS].ovf;
   assign drsp.rem_nz = |st_w[rti_pkg::QBITS].rem;
   assign drsp.q      = st_w[rti_pkg::QBITS].nq;

endmodule
`default_nettype wire

FILE: src/rti_point.sv
`default_nettype none
module rti_point #(
   parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic [rti_pkg::POINT_STAGES-1:0]  en,
   input  rti_pkg::ray_type                  ray,
   input  rti_pkg::div_rsp_type              drsp,
   output logic                              hit,
   output logic [2:0][rti_pkg::CW-1:0]       pt
);

   localparam int CW = rti_pkg::CW;
   localparam int PW = rti_pkg::PW;

   logic [rti_pkg::QBITS-1:0]       t;
   logic                            hit1_in, hit1_ff, hit2_ff;
   logic signed [CW+rti_pkg::TLO:0] plo_in [3], plo_ff [3];
   logic signed [2*CW-1:0]          phi_in [3], phi_ff [3];
   logic signed [PW-1:0]            prod [3];
   logic signed [PW:0]              sum [3];
   logic [2:0][CW-1:0]              pt_in, pt_ff;

   always_comb begin
      t = drsp.ovf ? {rti_pkg::QBITS{1'b1}} : drsp.q;
      hit1_in = drsp.hit
             && (drsp.ovf || (drsp.q > rti_pkg::QBITS'(ray.tol))
                 || ((drsp.q == rti_pkg::QBITS'(ray.tol)) && drsp.rem_nz));
      for (int k = 0; k < 3; k++) begin
         plo_in[k] = $signed(ray.dir[k]) * $signed({1'b0, t[rti_pkg::TLO-1:0]});
         phi_in[k] = $signed(ray.dir[k]) * $signed({1'b0, t[rti_pkg::QBITS-1:rti_pkg::TLO]});
      end
   end

   // origin plus scaled direction, saturated; zero on a miss
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = (PW'(phi_ff[k]) <<< rti_pkg::TLO) + PW'(plo_ff[k]);
         sum[k]  = (PW+1)'(prod[k] >>> FRAC_BITS) + (PW+1)'($signed(ray.org[k]));
         if (!hit1_ff) begin
            pt_in[k] = '0;
         end else if ((sum[k][PW:CW-1] == '0) || (sum[k][PW:CW-1] == '1)) begin
            pt_in[k] = sum[k][CW-1:0];
         end else begin
            pt_in[k] = sum[k][PW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hit1_ff <= hit1_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
      end
      if (en[1]) begin
         hit2_ff <= hit1_ff;
         pt_ff   <= pt_in;
      end
   end

   assign hit = hit2_ff;
   assign pt  = pt_ff;

endmodule
`default_nettype wire

FILE: src/ray_triangle_intersect_top.sv
// channel   dir   beat
// req_*     in    one triangle, three vertices
// rsp_*     out   hit flag and intersection point
// csr_*     in    ray origin, direction, tolerance writes
//
// one triangle per cycle while rsp is not stalled; the divider is bit-per-stage
// every stage carries a valid bit; a stalled rsp holds each full stage that has only full stages ahead of it
// req_tready stays high while any stage toward the output is empty
// synchronous reset clears valid bits and restores the ray registers
`default_nettype none
module ray_triangle_intersect_top #(
   parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
   input  logic [rti_pkg::REQW-1:0]     req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // hit, hit_x, hit_y, hit_z, zero pad
   output logic [rti_pkg::RSPW-1:0]     rsp_tdata,
   input  logic                         csr_we,
   input  logic [rti_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [rti_pkg::CW-1:0]       csr_wdata
);

   localparam int DOT_BASE = rti_pkg::FRONT_STAGES;
   localparam int DIV_BASE = DOT_BASE + rti_pkg::DOT_STAGES;
   localparam int PT_BASE  = DIV_BASE + rti_pkg::QBITS;
   localparam int NS       = PT_BASE + rti_pkg::POINT_STAGES;

   rti_pkg::ray_type                ray_in, ray_ff;
   logic [NS-1:0]                   vld_in, vld_ff;
   logic [NS:0]                     en;
   logic [8:0][rti_pkg::CW-1:0]     vert;
   logic signed [rti_pkg::EW-1:0]   e1 [3], e2 [3], sv [3];
   logic signed [rti_pkg::HW-1:0]   h [3];
   logic signed [rti_pkg::QW-1:0]   q [3];
   rti_pkg::div_req_type            dreq;
   rti_pkg::div_rsp_type            drsp;
   logic                            rsp_hit;
   logic [2:0][rti_pkg::CW-1:0]     rsp_pt;

   always_comb begin
      ray_in = ray_ff;
      if (csr_we) begin
         unique case (rti_pkg::csr_idx_type'(csr_addr))
            rti_pkg::CSR_ORG_X: ray_in.org[0] = csr_wdata;
            rti_pkg::CSR_ORG_Y: ray_in.org[1] = csr_wdata;
            rti_pkg::CSR_ORG_Z: ray_in.org[2] = csr_wdata;
            rti_pkg::CSR_DIR_X: ray_in.dir[0] = csr_wdata;
            rti_pkg::CSR_DIR_Y: ray_in.dir[1] = csr_wdata;
            rti_pkg::CSR_DIR_Z: ray_in.dir[2] = csr_wdata;
            rti_pkg::CSR_TOL:   ray_in.tol    = csr_wdata[rti_pkg::TOLW-1:0];
            default:            ray_in        = ray_ff;
         endcase
      end
   end

   // stage advances when empty or when the next one advances
   assign en[NS] = rsp_tready;
   for (genvar k = 0; k < NS; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   always_comb begin
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff         <= '0;
         ray_ff.org     <= '0;
         ray_ff.dir[0]  <= '0;
         ray_ff.dir[1]  <= '0;
         ray_ff.dir[2]  <= rti_pkg::DIR_Z_RST;
         ray_ff.tol     <= rti_pkg::TOL_RST;
      end else begin
         vld_ff <= vld_in;
         ray_ff <= ray_in;
      end
   end

   assign vert = req_tdata;

   rti_front u_front (
      .clock (clock),
      .en    (en[rti_pkg::FRONT_STAGES-1:0]),
      .ray   (ray_ff),
      .vert  (vert),
      .e1_o  (e1),
      .e2_o  (e2),
      .s_o   (sv),
      .h_o   (h),
      .q_o   (q)
   );

   rti_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clock (clock),
      .en    (en[DOT_BASE +: rti_pkg::DOT_STAGES]),
      .ray   (ray_ff),
      .e1    (e1),
      .e2    (e2),
      .s     (sv),
      .h     (h),
      .q     (q),
      .dreq  (dreq)
   );

   rti_div u_div (
      .clock (clock),
      .en    (en[DIV_BASE +: rti_pkg::QBITS]),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   rti_point #(.FRAC_BITS(FRAC_BITS)) u_point (
      .clock (clock),
      .en    (en[PT_BASE +: rti_pkg::POINT_STAGES]),
      .ray   (ray_ff),
      .drsp  (drsp),
      .hit   (rsp_hit),
      .pt    (rsp_pt)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {{(rti_pkg::RSPW - 1 - 3 * rti_pkg::CW){1'b0}},
                        rsp_pt[2], rsp_pt[1], rsp_pt[0], rsp_hit};

`ifndef SYNTHESIS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted beat not in first stage");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> req_tready)
      else $error("ready low with empty first stage");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_hit) |-> (rsp_pt == '0))
      else $error("miss with nonzero point");

   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NS-1] && !rsp_tready) |=> vld_ff[NS-1])
      else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

FILE: tb/ray_triangle_intersect_top_test.sv
`timescale 1ns / 100ps
module ray_triangle_intersect_top_test;

   typedef logic signed [191:0] wide_type;
   typedef struct packed {
      logic                      hit;
      logic [rti_pkg::CW-1:0]    x;
      logic [rti_pkg::CW-1:0]    y;
      logic [rti_pkg::CW-1:0]    z;
   } hit_type;

   localparam int ONE = 65536;
   localparam int IDLE_LIMIT = 4000;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [rti_pkg::REQW-1:0]     req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [rti_pkg::RSPW-1:0]     rsp_tdata;
   logic                         csr_we = 1'b0;
   logic [rti_pkg::CSR_AW-1:0]   csr_addr = '0;
   logic [rti_pkg::CW-1:0]       csr_wdata = '0;

   logic [rti_pkg::REQW-1:0]     tri_queue [$];
   hit_type                      hit_expect [$];
   logic signed [rti_pkg::CW-1:0] ray_org [3];
   logic signed [rti_pkg::CW-1:0] ray_dir [3];
   logic [rti_pkg::TOLW-1:0]     ray_tol;
   bit               failed = 1'b0;
   bit               quiet = 1'b0;
   bit               req_fire = 1'b0;
   int               req_gap = 0;
   int               rsp_gap = 0;
   int               idle_cycles = 0;

   ray_triangle_intersect_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [rti_pkg::CW-1:0] clamp32(wide_type v);
      if (v > wide_type'(32'sh7fff_ffff)) return 32'h7fff_ffff;
      if (v < wide_type'(-64'sd2147483648)) return 32'h8000_0000;
      return v[rti_pkg::CW-1:0];
   endfunction

   function automatic hit_type predict_hit(logic [rti_pkg::REQW-1:0] tri_w);
      wide_type p0 [3], ea [3], eb [3], sv [3], dd [3], hh [3], qq [3];
      wide_type det, un, vn, tn, tw, tq, cap;
      hit_type r;
      int m, n;
      r = '0;
      for (int k = 0; k < 3; k++) begin
         p0[k] = $signed(tri_w[32*k +: 32]);
         ea[k] = wide_type'($signed(tri_w[32*(3+k) +: 32])) - p0[k];
         eb[k] = wide_type'($signed(tri_w[32*(6+k) +: 32])) - p0[k];
         sv[k] = wide_type'(ray_org[k]) - p0[k];
         dd[k] = ray_dir[k];
      end
      for (int k = 0; k < 3; k++) begin
         m = (k + 1) % 3;
         n = (k + 2) % 3;
         hh[k] = dd[m] * eb[n] - dd[n] * eb[m];
         qq[k] = sv[m] * ea[n] - sv[n] * ea[m];
      end
      det = 0; un = 0; vn = 0; tn = 0;
      for (int k = 0; k < 3; k++) begin
         det = det + ea[k] * hh[k];
         un  = un + sv[k] * hh[k];
         vn  = vn + dd[k] * qq[k];
         tn  = tn + eb[k] * qq[k];
      end
      if (det < 0) begin
         det = -det; un = -un; vn = -vn; tn = -tn;
      end
      tw = wide_type'({1'b0, ray_tol});
      if (det == 0 || det < (tw <<< 32)) return r;
      if (un < 0 || un > det) return r;
      if (vn < 0 || un + vn > det) return r;
      if ((tn <<< 16) <= tw * det) return r;
      tq = (tn <<< 16) / det;
      cap = (wide_type'(1) <<< 63) - 1;
      if (tq > cap) tq = cap;
      r.hit = 1'b1;
      r.x = clamp32(wide_type'(ray_org[0]) + ((dd[0] * tq) >>> 16));
      r.y = clamp32(wide_type'(ray_org[1]) + ((dd[1] * tq) >>> 16));
      r.z = clamp32(wide_type'(ray_org[2]) + ((dd[2] * tq) >>> 16));
      return r;
   endfunction

   // sender
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (tri_queue.size() > 0) begin
            req_tdata <= tri_queue.pop_front();
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 11) == 0) req_gap <= $urandom_range(1, 13);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 11) == 0) rsp_gap <= $urandom_range(1, 13);
      end
   end

   always @(posedge clock) begin
      hit_type got, want;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) hit_expect = {hit_expect, predict_hit(req_tdata)};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tdata[0];
         got.x   = rsp_tdata[32:1];
         got.y   = rsp_tdata[64:33];
         got.z   = rsp_tdata[96:65];
         if (hit_expect.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_tdata);
            failed = 1'b1;
         end else begin
            want = hit_expect.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
               failed = 1'b1;
            end
            if (got.x !== want.x) begin
               $display("%0t: hit_x expected %h actual %h", $time, want.x, got.x);
               failed = 1'b1;
            end
            if (got.y !== want.y) begin
               $display("%0t: hit_y expected %h actual %h", $time, want.y, got.y);
               failed = 1'b1;
            end
            if (got.z !== want.z) begin
               $display("%0t: hit_z expected %h actual %h", $time, want.z, got.z);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (tri_queue.size() == 0 && hit_expect.size() == 0 && !req_tvalid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[ray_triangle_intersect_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(rti_pkg::csr_idx_type idx, logic [rti_pkg::CW-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      unique case (idx)
         rti_pkg::CSR_ORG_X, rti_pkg::CSR_ORG_Y, rti_pkg::CSR_ORG_Z:
            ray_org[idx - rti_pkg::CSR_ORG_X] = value;
         rti_pkg::CSR_DIR_X, rti_pkg::CSR_DIR_Y, rti_pkg::CSR_DIR_Z:
            ray_dir[idx - rti_pkg::CSR_DIR_X] = value;
         rti_pkg::CSR_TOL: ray_tol = value[rti_pkg::TOLW-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_ray(logic [rti_pkg::CW-1:0] ox, oy, oz, dx, dy, dz,
                          logic [rti_pkg::TOLW-1:0] tol);
      write_reg(rti_pkg::CSR_ORG_X, ox);
      write_reg(rti_pkg::CSR_ORG_Y, oy);
      write_reg(rti_pkg::CSR_ORG_Z, oz);
      write_reg(rti_pkg::CSR_DIR_X, dx);
      write_reg(rti_pkg::CSR_DIR_Y, dy);
      write_reg(rti_pkg::CSR_DIR_Z, dz);
      write_reg(rti_pkg::CSR_TOL, {16'h0, tol});
   endtask

   task automatic drain();
      while (tri_queue.size() > 0 || hit_expect.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [rti_pkg::REQW-1:0] unit_tri(int a [9]);
      logic [rti_pkg::REQW-1:0] r;
      for (int k = 0; k < 9; k++) r[32*k +: 32] = a[k] * ONE;
      return r;
   endfunction

   function automatic logic [rti_pkg::CW-1:0] small_val(int span);
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // triangle around a point on the ray, mostly hit
   function automatic logic [rti_pkg::REQW-1:0] ray_tri();
      logic [rti_pkg::REQW-1:0] r;
      logic signed [63:0] c [3], a, b;
      int steps, span;
      steps = $urandom_range(0, 6);
      span = 1 << $urandom_range(4, 20);
      for (int k = 0; k < 3; k++)
         c[k] = 64'(ray_org[k]) + 64'(ray_dir[k]) * steps + $signed(small_val(span >> 3));
      for (int k = 0; k < 3; k++) begin
         a = $signed(small_val(span));
         b = $signed(small_val(span));
         r[32*k +: 32]     = 32'(c[k] + a);
         r[32*(3+k) +: 32] = 32'(c[k] + b);
         r[32*(6+k) +: 32] = 32'(c[k] - a - b);
      end
      return r;
   endfunction

   function automatic logic [rti_pkg::REQW-1:0] noise_tri();
      logic [rti_pkg::REQW-1:0] r;
      for (int k = 0; k < 9; k++) r[32*k +: 32] = $urandom();
      return r;
   endfunction

   task automatic add_tri(logic [rti_pkg::REQW-1:0] t);
      tri_queue = {tri_queue, t};
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         add_tri($urandom_range(0, 4) == 0 ? noise_tri() : ray_tri());
   endtask

   initial begin
      ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
      ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = rti_pkg::DIR_Z_RST;
      ray_tol = rti_pkg::TOL_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_tri(unit_tri('{-1, -1, 5, 3, -1, 5, -1, 3, 5}));
      add_tri(unit_tri('{-1, -1, -5, 3, -1, -5, -1, 3, -5}));
      add_tri(unit_tri('{1, 1, 5, 3, 1, 5, 1, 3, 5}));
      add_tri(unit_tri('{-3, 1, 5, -1, 1, 5, -3, 3, 5}));
      add_tri(unit_tri('{1, -3, 5, 3, -3, 5, 1, -1, 5}));
      add_tri(unit_tri('{1, -1, 5, -1, 1, 5, 1, 1, 5}));
      add_tri(unit_tri('{0, 0, 0, 1, 0, 0, 0, 0, 1}));
      add_tri(unit_tri('{2, 2, 2, 2, 2, 2, 2, 2, 2}));
      add_tri(unit_tri('{0, 0, 5, 1, 0, 5, 0, 1, 5}));
      add_tri(unit_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
      add_tri({9{32'h8000_0000}});
      add_tri({9{32'h7fff_ffff}});
      add_tri({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff});
      add_tri({32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
               32'h8000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff});
      drain();

      // tolerance zero, then maximal
      set_ray(0, 0, 0, 0, 0, ONE, 0);
      add_tri(unit_tri('{-1, -1, 5, 3, -1, 5, -1, 3, 5}));
      add_tri(unit_tri('{0, 0, 0, 1, 0, 0, 0, 0, 1}));
      drain();
      set_ray(0, 0, 0, 0, 0, ONE, 16'hffff);
      add_tri(unit_tri('{-1, -1, 5, 3, -1, 5, -1, 3, 5}));
      add_tri(unit_tri('{-100, -100, 5, 300, -100, 5, -100, 300, 5}));
      random_phase(150);
      drain();

      // extreme ray registers
      set_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
      random_phase(150);
      drain();
      set_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 0);
      random_phase(150);
      drain();

      for (int p = 0; p < 7; p++) begin
         set_ray(small_val(1 << 22), small_val(1 << 22), small_val(1 << 22),
                 small_val(1 << 18), small_val(1 << 18), small_val(1 << 18),
                 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16'hffff)
                                               : $urandom_range(0, 8)));
         random_phase(155);
         if (p == 3) begin
            // full random ray with noise triangles
            drain();
            set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), 16'($urandom_range(0, 16'hffff)));
            for (int i = 0; i < 100; i++) add_tri(noise_tri());
         end
         drain();
      end

      quiet = 1'b1;
      set_ray(0, 0, 0, small_val(1 << 16), small_val(1 << 16), ONE, 1);
      random_phase(200);
      drain();

      if (!failed) begin
         $display("[ray_triangle_intersect_top] OK");
      end else begin
         $display("[ray_triangle_intersect_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/rti_pkg.sv
src/rti_front.sv
src/rti_dot.sv
src/rti_div.sv
src/rti_point.sv
src/ray_triangle_intersect_top.sv
tb/ray_triangle_intersect_top_test.sv
